>>> hw/rtl/odo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package odo_pkg;

  localparam int ANGLE_BITS     = 32;
  localparam int SINE_BITS      = 16;
  localparam int DELTA_BITS     = 16;
  localparam int QUARTER_BITS   = 10;
  localparam int QUARTER_SIZE   = 1 << QUARTER_BITS;
  localparam int ROM_W          = 25;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;
  localparam int OUT_W          = 160;

  localparam logic [CFG_INDEX_BITS-1:0] REG_TURN_RIGHT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TURN_LEFT  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DIST_RIGHT = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DIST_LEFT  = 2'd3;

  localparam logic [31:0] TURN_RESET = 32'd42949673;
  localparam logic [23:0] DIST_RESET = 24'd205887;

  typedef struct packed {
    logic [31:0] turn_right;
    logic [31:0] turn_left;
    logic [23:0] dist_right;
    logic [23:0] dist_left;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic       pop;
    logic [1:0] count;
  } queue_status_t;

  typedef logic [ROM_W-1:0] rom_t [0:QUARTER_SIZE];

  // Quarter-wave sine by a ten-term series in Q30, rounded to sb fraction bits.
  function automatic rom_t build_sine(input int sb);
    rom_t r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] v;
    logic signed [63:0] acc;
    for (int k = 0; k <= QUARTER_SIZE; k++) begin
      x   = (PI_HALF_Q30 * 64'(k) + 64'(QUARTER_SIZE / 2)) / QUARTER_SIZE;
      x2  = (x * x) >> 30;
      t   = x;
      acc = signed'(x);
      t = ((t * x2) >> 30) / 64'd6;   acc = acc - signed'(t);
      t = ((t * x2) >> 30) / 64'd20;  acc = acc + signed'(t);
      t = ((t * x2) >> 30) / 64'd42;  acc = acc - signed'(t);
      t = ((t * x2) >> 30) / 64'd72;  acc = acc + signed'(t);
      t = ((t * x2) >> 30) / 64'd110; acc = acc - signed'(t);
      t = ((t * x2) >> 30) / 64'd156; acc = acc + signed'(t);
      t = ((t * x2) >> 30) / 64'd210; acc = acc - signed'(t);
      t = ((t * x2) >> 30) / 64'd272; acc = acc + signed'(t);
      t = ((t * x2) >> 30) / 64'd342; acc = acc - signed'(t);
      if (acc < 0) acc = 0;
      v = ((unsigned'(acc) << sb) + 64'(1 << 29)) >> 30;
      if (v > (64'd1 << sb)) v = 64'd1 << sb;
      r[k] = v[ROM_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/odo_front.sv
`timescale 1ns / 1ps
`default_nettype none
module odo_front #(
  parameter int DELTA_BITS = odo_pkg::DELTA_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [2*DELTA_BITS-1:0] in_data,
  input  wire logic                    pop,
  output logic [2*DELTA_BITS-1:0]      q_data,
  output odo_pkg::queue_status_t       status
);

  logic [2*DELTA_BITS-1:0] mem [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       do_pop;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign do_pop   = pop && (count != 2'd0);
  assign q_data   = mem[rd_ptr];

  assign status.valid = (count != 2'd0);
  assign status.pop   = pop;
  assign status.count = count;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/odo_back.sv
`timescale 1ns / 1ps
`default_nettype none
module odo_back #(
  parameter int ANGLE_BITS = odo_pkg::ANGLE_BITS,
  parameter int SINE_BITS  = odo_pkg::SINE_BITS,
  parameter int DELTA_BITS = odo_pkg::DELTA_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire odo_pkg::cfg_t           cfg,
  input  wire logic                    q_valid,
  input  wire logic [2*DELTA_BITS-1:0] q_data,
  output logic                         pop,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [odo_pkg::OUT_W-1:0]    out_data
);

  localparam int QS  = odo_pkg::QUARTER_SIZE;
  localparam int IW  = odo_pkg::QUARTER_BITS + 1;
  localparam int SH  = ANGLE_BITS - 2 - odo_pkg::QUARTER_BITS;
  localparam int TW  = ANGLE_BITS + 1;
  localparam int AW  = DELTA_BITS + 26;
  localparam int UW  = DELTA_BITS + 24;
  localparam int HW  = (UW + 1) / 2;
  localparam int MW  = SINE_BITS + 1;
  localparam int MA  = 33;
  localparam int MB  = (DELTA_BITS > SINE_BITS + 2) ? DELTA_BITS : SINE_BITS + 2;
  localparam int PW  = MA + MB;
  localparam int LW  = HW + MW;
  localparam int RW  = UW + MW;
  localparam int SW  = UW + 3;

  localparam odo_pkg::rom_t SINE = odo_pkg::build_sine(SINE_BITS);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_TH1  = 4'd1;
  localparam logic [3:0] ST_TH2  = 4'd2;
  localparam logic [3:0] ST_AD1  = 4'd3;
  localparam logic [3:0] ST_AD2  = 4'd4;
  localparam logic [3:0] ST_RA   = 4'd5;
  localparam logic [3:0] ST_RB   = 4'd6;
  localparam logic [3:0] ST_SEL  = 4'd7;
  localparam logic [3:0] ST_X0   = 4'd8;
  localparam logic [3:0] ST_X1   = 4'd9;
  localparam logic [3:0] ST_X2   = 4'd10;
  localparam logic [3:0] ST_Y1   = 4'd11;
  localparam logic [3:0] ST_Y2   = 4'd12;
  localparam logic [3:0] ST_FIN  = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  logic signed [DELTA_BITS-1:0] dl;
  logic signed [DELTA_BITS-1:0] dr;
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic [TW-1:0] th;
  logic signed [AW-1:0] adv;
  logic [UW-1:0] ua;
  logic [ANGLE_BITS-1:0] mid;
  logic [ANGLE_BITS-1:0] heading;
  logic [ANGLE_BITS-2:0] idx_sum;
  logic [IW-1:0] idx;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] rom_addr;
  logic [MW-1:0] rom_q;
  logic [MW-1:0] a_mag;
  logic [1:0] quad;
  logic [MW-1:0] c_mag;
  logic [MW-1:0] s_mag;
  logic c_neg;
  logic s_neg;
  logic [LW-1:0] racc;
  logic [RW-1:0] full;
  logic [UW:0] r;
  logic [31:0] x;
  logic [31:0] y;
  logic [31:0] total_left;
  logic [31:0] total_right;
  logic out_free;

  function automatic logic [31:0] sat_add(input logic [31:0] v, input logic neg,
                                          input logic [UW:0] m);
    logic signed [SW-1:0] sum;
    sum = SW'(signed'(v)) + (neg ? -signed'(SW'(m)) : signed'(SW'(m)));
    if (sum > signed'(SW'(32'h7fffffff))) return 32'h7fffffff;
    if (sum < -signed'(SW'(33'h080000000))) return 32'h80000000;
    return sum[31:0];
  endfunction

  assign out_free = !out_valid || out_ready;
  assign pop      = (state == ST_IDLE) && q_valid;

  // Round the quarter-turn phase to the nearest table index.
  assign idx_sum = {1'b0, mid[ANGLE_BITS-3:0]} + (ANGLE_BITS-1)'(1 << (SH - 1));
  assign idx     = idx_sum[ANGLE_BITS-2:SH];
  assign full    = RW'(racc) + (RW'(prod[LW-1:0] & {LW{1'b1}}) << HW)
                 + RW'(1 << (SINE_BITS - 1));
  assign r       = full[RW-1:SINE_BITS];

  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    rom_addr = idx;
    case (state)
      ST_TH1: begin
        mul_a = signed'(MA'(cfg.turn_right));
        mul_b = MB'(dr);
      end
      ST_TH2: begin
        mul_a = signed'(MA'(cfg.turn_left));
        mul_b = MB'(dl);
      end
      ST_AD1: begin
        mul_a = signed'(MA'(cfg.dist_right));
        mul_b = MB'(dr);
      end
      ST_AD2: begin
        mul_a = signed'(MA'(cfg.dist_left));
        mul_b = MB'(dl);
      end
      ST_RB: rom_addr = IW'(QS) - idx_r;
      ST_X0: begin
        mul_a = signed'(MA'(ua[HW-1:0]));
        mul_b = signed'(MB'(c_mag));
      end
      ST_X1: begin
        mul_a = signed'(MA'(ua[UW-1:HW]));
        mul_b = signed'(MB'(c_mag));
      end
      ST_X2: begin
        mul_a = signed'(MA'(ua[HW-1:0]));
        mul_b = signed'(MB'(s_mag));
      end
      ST_Y1: begin
        mul_a = signed'(MA'(ua[UW-1:HW]));
        mul_b = signed'(MB'(s_mag));
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (q_valid) state_next = ST_TH1;
      ST_TH1:  state_next = ST_TH2;
      ST_TH2:  state_next = ST_AD1;
      ST_AD1:  state_next = ST_AD2;
      ST_AD2:  state_next = ST_RA;
      ST_RA:   state_next = ST_RB;
      ST_RB:   state_next = ST_SEL;
      ST_SEL:  state_next = ST_X0;
      ST_X0:   state_next = ST_X1;
      ST_X1:   state_next = ST_X2;
      ST_X2:   state_next = ST_Y1;
      ST_Y1:   state_next = ST_Y2;
      ST_Y2:   state_next = ST_FIN;
      ST_FIN:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod  <= mul_a * mul_b;
    rom_q <= SINE[rom_addr][MW-1:0];
    case (state)
      ST_IDLE: begin
        dl <= q_data[DELTA_BITS-1:0];
        dr <= q_data[2*DELTA_BITS-1:DELTA_BITS];
      end
      ST_TH2: th <= prod[TW-1:0];
      ST_AD1: th <= th - prod[TW-1:0];
      ST_AD2: begin
        adv <= prod[AW-1:0];
        mid <= heading + th[TW-1:1];
      end
      ST_RA: begin
        adv   <= adv + prod[AW-1:0];
        idx_r <= idx;
        quad  <= mid[ANGLE_BITS-1:ANGLE_BITS-2];
      end
      ST_RB: begin
        ua    <= adv[AW-1] ? UW'(-adv) : UW'(adv);
        a_mag <= rom_q;
      end
      ST_SEL: begin
        // rom_q holds the cosine-side entry of the quadrant
        case (quad)
          2'd0: begin
            s_mag <= a_mag; c_mag <= rom_q; s_neg <= 1'b0; c_neg <= 1'b0;
          end
          2'd1: begin
            s_mag <= rom_q; c_mag <= a_mag; s_neg <= 1'b0; c_neg <= 1'b1;
          end
          2'd2: begin
            s_mag <= a_mag; c_mag <= rom_q; s_neg <= 1'b1; c_neg <= 1'b1;
          end
          default: begin
            s_mag <= rom_q; c_mag <= a_mag; s_neg <= 1'b1; c_neg <= 1'b0;
          end
        endcase
      end
      ST_X1: racc <= prod[LW-1:0];
      ST_Y1: racc <= prod[LW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      x           <= '0;
      y           <= '0;
      heading     <= '0;
      total_left  <= '0;
      total_right <= '0;
    end else begin
      state <= state_next;
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_X2: x <= sat_add(x, c_neg ^ adv[AW-1], r);
        ST_Y2: y <= sat_add(y, s_neg ^ adv[AW-1], r);
        ST_FIN: begin
          if (out_free) begin
            heading     <= heading + th[ANGLE_BITS-1:0];
            total_left  <= total_left + 32'(dl);
            total_right <= total_right + 32'(dr);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      out_data <= {total_right + 32'(dr), total_left + 32'(dl),
                   32'(heading + th[ANGLE_BITS-1:0]), y, x};
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/diff_drive_odometry_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Differential-drive odometry with midpoint heading.
// Input stream (s_axis): one request per encoder sample, left and right count
// deltas. A two-entry queue takes requests while the sequencer works, so the
// sender sees tready low only when two samples are already waiting.
// Output stream (m_axis): one pose per sample, x and y in Q16.16 mm
// (saturating), heading as a binary angle, and the wrapping count totals.
// Config channel (cfg_*): always ready; write only while no sample is in
// flight. Index 0/1 turn per right/left count, 2/3 half travel per count.
// Sequence, one sample at a time: the pop step, two heading terms and two
// advance terms on the single shared multiplier, two sine table reads with the
// quadrant select, two partial products each for x and y on that multiplier,
// and the final output step.
// Reset: all totals, pose and heading clear, gains take their defaults.
// Stall: the finished pose holds in the output register; the sequencer
// waits at its last step, and the queue keeps accepting until full.
module diff_drive_odometry_unit #(
  parameter int ANGLE_BITS = odo_pkg::ANGLE_BITS,
  parameter int SINE_BITS  = odo_pkg::SINE_BITS,
  parameter int DELTA_BITS = odo_pkg::DELTA_BITS,
  parameter int IN_W       = ((2 * DELTA_BITS + 7) / 8) * 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // delta_left, delta_right
  input  wire logic [IN_W-1:0]                     s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // pos_x, pos_y, heading, total_left, total_right
  output logic [odo_pkg::OUT_W-1:0]                m_axis_tdata,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [odo_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [odo_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  odo_pkg::cfg_t           cfg;
  odo_pkg::queue_status_t  qstat;
  logic [2*DELTA_BITS-1:0] q_data;
  logic                    pop;

  assign cfg_ready = 1'b1;

  // Hold gains; a write lands at its index.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.turn_right <= odo_pkg::TURN_RESET;
      cfg.turn_left  <= odo_pkg::TURN_RESET;
      cfg.dist_right <= odo_pkg::DIST_RESET;
      cfg.dist_left  <= odo_pkg::DIST_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        odo_pkg::REG_TURN_RIGHT: cfg.turn_right <= cfg_data;
        odo_pkg::REG_TURN_LEFT:  cfg.turn_left  <= cfg_data;
        odo_pkg::REG_DIST_RIGHT: cfg.dist_right <= cfg_data[23:0];
        odo_pkg::REG_DIST_LEFT:  cfg.dist_left  <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  odo_front #(
    .DELTA_BITS(DELTA_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata[2*DELTA_BITS-1:0]),
    .pop      (pop),
    .q_data   (q_data),
    .status   (qstat)
  );

  odo_back #(
    .ANGLE_BITS(ANGLE_BITS),
    .SINE_BITS (SINE_BITS),
    .DELTA_BITS(DELTA_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (qstat.valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.count != 2'd3) else $error("queue count out of range");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    qstat.pop |-> qstat.valid) else $error("pop from empty queue");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> qstat.count == 2'd2) else $error("ready low with room");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid) else $error("output valid after reset");

endmodule
`default_nettype wire

>>> dv/tb_diff_drive_odometry_unit.sv
`timescale 1ns / 1ps
module tb_diff_drive_odometry_unit;

  // One pose as it leaves the block, packed from the lowest bit up:
  // pos_x, pos_y, heading, total_left, total_right.
  typedef struct {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] heading;
    logic [31:0] total_left;
    logic [31:0] total_right;
  } pose_t;

  localparam int QTR      = 1024;
  localparam int LIMIT    = 600000;
  localparam int SETTLE   = 40;
  localparam int HOLD_LEN = 400;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata;    // delta_left [15:0], delta_right [31:16]
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [159:0] m_axis_tdata;    // pos_x, pos_y, heading, total_left, total_right
  logic         cfg_valid;
  logic         cfg_ready;
  logic [odo_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [odo_pkg::CFG_DATA_BITS-1:0]  cfg_data;

  diff_drive_odometry_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the gains and of the pose state
  logic [31:0] gain_turn_r, gain_turn_l;
  logic [23:0] gain_dist_r, gain_dist_l;
  logic [31:0] st_x, st_y, st_heading, st_left, st_right;
  longint      sine_tab [0:QTR];

  pose_t pose_q [$];
  int    mismatches;
  int    cycles;
  bit    gaps_off;       // stretch with the sender never idling
  bit    hold_req;       // ask the receiver for one long hold-off

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Quarter-wave sine by the same ten-term series, Q30 then rounded to 16 bits
  task automatic fill_sine_tab();
    longint unsigned x, x2, term, v;
    longint acc;
    for (int k = 0; k <= QTR; k++) begin
      x    = (64'd1686629713 * k + QTR / 2) / QTR;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 9; n++) begin
        term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
        if (n % 2 == 1) acc = acc - longint'(term);
        else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      v = ((longint'(acc) << 16) + (64'd1 << 29)) >> 30;
      if (v > (64'd1 << 16)) v = 64'd1 << 16;
      sine_tab[k] = longint'(v);
    end
  endtask

  // Round half up on the magnitude of a*t / 2^16, then restore the sign
  function automatic longint scaled_product(longint a, longint t);
    longint unsigned ua, ut, r;
    bit neg;
    neg = (a < 0) != (t < 0);
    ua  = (a < 0) ? -a : a;
    ut  = (t < 0) ? -t : t;
    r   = (ua >> 16) * ut + (((ua & 64'hFFFF) * ut + 64'h8000) >> 16);
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic [31:0] clamp_add(logic [31:0] cur, longint d);
    longint v;
    v = longint'(signed'(cur)) + d;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // Advance the shadow pose by one encoder sample and return the new pose
  function automatic pose_t advance_pose(logic signed [15:0] dl, logic signed [15:0] dr);
    longint dth, adv, half, sn, cs, a, b;
    logic [31:0] mid;
    int idx;
    pose_t p;
    dth  = longint'({32'd0, gain_turn_r}) * dr - longint'({32'd0, gain_turn_l}) * dl;
    adv  = longint'({40'd0, gain_dist_r}) * dr + longint'({40'd0, gain_dist_l}) * dl;
    half = dth >>> 1;
    mid  = st_heading + half[31:0];
    idx  = int'((longint'(mid[29:0]) + (64'd1 << 19)) >> 20);
    a    = sine_tab[idx];
    b    = sine_tab[QTR - idx];
    case (mid[31:30])
      2'd0: begin sn = a;  cs = b;  end
      2'd1: begin sn = b;  cs = -a; end
      2'd2: begin sn = -a; cs = -b; end
      default: begin sn = -b; cs = a; end
    endcase
    st_x       = clamp_add(st_x, scaled_product(adv, cs));
    st_y       = clamp_add(st_y, scaled_product(adv, sn));
    st_heading = mid + 32'(dth - half);
    st_left    = st_left + {{16{dl[15]}}, dl};
    st_right   = st_right + {{16{dr[15]}}, dr};
    p.pos_x = st_x; p.pos_y = st_y; p.heading = st_heading;
    p.total_left = st_left; p.total_right = st_right;
    return p;
  endfunction

  function automatic int pick_gap();
    int r;
    if (gaps_off) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one sample; the handshake is judged on values held over the edge.
  // Valid stays up between back-to-back samples and drops only for a gap.
  task automatic send_sample(logic signed [15:0] dl, logic signed [15:0] dr);
    bit taken;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dr, dl};
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = s_axis_tready;
      @(posedge clk);
    end
    pose_q.push_back(advance_pose(dl, dr));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write one gain register; only called with nothing in flight
  task automatic write_gain(logic [odo_pkg::CFG_INDEX_BITS-1:0] idx, logic [31:0] val);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end
    case (idx)
      odo_pkg::REG_TURN_RIGHT: gain_turn_r = val;
      odo_pkg::REG_TURN_LEFT:  gain_turn_l = val;
      odo_pkg::REG_DIST_RIGHT: gain_dist_r = val[23:0];
      default:                 gain_dist_l = val[23:0];
    endcase
  endtask

  task automatic load_gains(logic [31:0] tr, logic [31:0] tl, logic [31:0] dr, logic [31:0] dl);
    wait_drained();
    write_gain(odo_pkg::REG_TURN_RIGHT, tr);
    write_gain(odo_pkg::REG_TURN_LEFT, tl);
    write_gain(odo_pkg::REG_DIST_RIGHT, dr);
    write_gain(odo_pkg::REG_DIST_LEFT, dl);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_delta();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 16'($signed($urandom_range(0, 400)) - 200);
    if (r < 85) return 16'($urandom);
    case ($urandom_range(0, 3))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  // Extremes of both deltas, each single-wheel motion, odd heading changes
  task automatic test_directed();
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd1, 16'sd0);
    send_sample(16'sd0, 16'sd1);
    send_sample(-16'sd1, 16'sd0);
    send_sample(16'sd0, -16'sd1);
    send_sample(16'sd32767, 16'sd32767);
    send_sample(-16'sd32768, -16'sd32768);
    send_sample(16'sd32767, -16'sd32768);
    send_sample(-16'sd32768, 16'sd32767);
    send_sample(-16'sd25, 16'sd25);
    send_sample(16'sd3, 16'sd7);
    // push heading through a full turn in big steps to cross every quadrant
    for (int k = 0; k < 8; k++) send_sample(-16'sd12, 16'sd13);
  endtask

  // Zero gains freeze the pose; maximum gains drive x and y into saturation
  task automatic test_gain_extremes();
    load_gains(32'd0, 32'd0, 32'd0, 32'd0);
    send_sample(16'sd32767, -16'sd32768);
    send_sample(-16'sd5, 16'sd9);
    load_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF);
    for (int k = 0; k < 6; k++) send_sample(16'sd32767, 16'sd32767);
    for (int k = 0; k < 6; k++) send_sample(-16'sd32768, -16'sd32768);
    send_sample(16'sd32767, -16'sd32768);
  endtask

  // Receiver holds off long while samples keep coming; then the sender drains
  task automatic test_backpressure();
    wait_drained();
    gaps_off = 1'b1;
    hold_req = 1'b1;
    for (int k = 0; k < 8; k++) send_sample(rand_delta(), rand_delta());
    gaps_off = 1'b0;
    wait_drained();
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_gains(odo_pkg::TURN_RESET, odo_pkg::TURN_RESET,
                      32'(odo_pkg::DIST_RESET), 32'(odo_pkg::DIST_RESET));
        1: load_gains(32'hFFFF_FFFF, 32'd1, 32'h00FF_FFFF, 32'd0);
        2: load_gains(32'd0, 32'hFFFF_FFFF, 32'd1, 32'h00FF_FFFF);
        default: load_gains($urandom, $urandom, $urandom, $urandom);
      endcase
      for (int k = 0; k < 200; k++) begin
        if (k % 50 == 0) gaps_off = ($urandom_range(0, 3) == 0);
        send_sample(rand_delta(), rand_delta());
      end
      gaps_off = 1'b0;
    end
  endtask

  // Receiver: random stalls, plus one counted hold-off on request
  initial begin
    int hold;
    m_axis_tready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold_req && hold == 0) begin
        hold = HOLD_LEN;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold = hold - 1;
        m_axis_tready <= 1'b0;
      end else if (gaps_off) begin
        m_axis_tready <= 1'b1;
      end else begin
        case ($urandom_range(0, 9))
          0, 1: m_axis_tready <= 1'b0;
          2: begin
            m_axis_tready <= 1'b0;
            hold = $urandom_range(5, 40);
          end
          default: m_axis_tready <= 1'b1;
        endcase
      end
    end
  end

  // Checker: capture the result handshake before the edge, compare at the edge
  initial begin
    bit fire;
    logic [159:0] got;
    pose_t want;
    forever begin
      @(negedge clk);
      fire = m_axis_tvalid && m_axis_tready && !rst;
      got  = m_axis_tdata;
      @(posedge clk);
      if (fire) begin
        if (pose_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected pose %h", got);
        end else begin
          want = pose_q.pop_front();
          if (got != {want.total_right, want.total_left, want.heading,
                      want.pos_y, want.pos_x}) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pose mismatch: x %h/%h y %h/%h hd %h/%h tl %h/%h tr %h/%h (exp/got)",
                       want.pos_x, got[31:0], want.pos_y, got[63:32],
                       want.heading, got[95:64], want.total_left, got[127:96],
                       want.total_right, got[159:128]);
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    mismatches = 0;
    gaps_off = 1'b0;
    hold_req = 1'b0;
    gain_turn_r = odo_pkg::TURN_RESET; gain_turn_l = odo_pkg::TURN_RESET;
    gain_dist_r = odo_pkg::DIST_RESET; gain_dist_l = odo_pkg::DIST_RESET;
    st_x = '0; st_y = '0; st_heading = '0; st_left = '0; st_right = '0;
    fill_sine_tab();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_gain_extremes();
    test_backpressure();
    test_random();

    wait_drained();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
